>>> rtl/core/b64e_pkg.sv
package b64e_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [6:0] PAD_CHAR = 7'd61;  // '='
    localparam logic [5:0] SIX_MASK = 6'h3f;

    // one complete 24-bit group, ready for the character stage
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  pad_cnt;   // number of trailing '=' (0..2)
        logic        last;      // group closes the stream
    } group_t;

    // standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26)
            c = 7'd65 + {1'b0, v};
        else if (v < 6'd52)
            c = 7'd71 + {1'b0, v};          // 'a' - 26
        else if (v < 6'd62)
            c = {1'b0, v} - 7'd4;           // '0' - 52
        else if (v == 6'd62)
            c = 7'd43;                      // '+'
        else
            c = 7'd47;                      // '/'
        return c;
    endfunction

endpackage

>>> rtl/core/base64_stream_encoder_top.sv
// Streaming base64 encoder, standard alphabet with '=' padding.
// Input channel: one raw byte per beat (data_byte), last_byte set on the
//   final byte of a stream; in_valid/in_ready handshake.
// Output channel: one ASCII character per beat (out_char), last_char set
//   on the final character of the encoded stream; out_valid/out_ready.
// Every third byte, or a byte flagged last, closes a group of four
//   characters; a short final group is zero-filled and ends in one or two '='.
// Path: the beat that closes a group writes it into the group queue; the back
//   end loads it into its group register and then the output register.
// Throughput: the character stage emits one character per cycle while out_ready
//   is high, four characters per 3 bytes; the input takes a byte every cycle
//   until the group queue (QUEUE_DEPTH entries) fills.
// Stall: when the receiver holds out_ready low the output register holds its
//   beat, the group queue fills, and then in_ready drops.
// Reset: clears held bytes, the group count, the queue and the output valid;
//   in_ready is high from reset on, so a byte can be taken as soon as reset
//   is released.
module base64_stream_encoder_top
    import b64e_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] out_char,
    output logic       last_char
);

    group_t push_group;
    group_t q_group;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;

    // byte collection and group classification
    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .q_full     (q_full),
        .push       (push),
        .push_group (push_group)
    );

    // decouples byte intake from character output
    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_group    (q_group)
    );

    // sextet select, alphabet lookup, padding, output register
    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_group   (q_group),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last_char (last_char)
    );

endmodule

>>> rtl/core/b64e_front.sv
module b64e_front
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       q_full,
    output logic       push,
    output group_t     push_group
);

    logic [15:0] pending_reg, pending_next;
    logic [1:0]  count_reg, count_next;
    logic [1:0]  cnt_eff;
    logic        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign cnt_eff  = (count_reg == 2'd3) ? 2'd0 : count_reg;

    always_comb
    begin
        pending_next       = pending_reg;
        count_next         = count_reg;
        push               = 1'b0;
        push_group.word    = {pending_reg, data_byte};
        push_group.pad_cnt = 2'd0;
        push_group.last    = last_byte;
        if (accept)
        begin
            priority if (cnt_eff == 2'd2)
            begin
                push         = 1'b1;
                pending_next = '0;
                count_next   = '0;
            end
            else if (!last_byte)
            begin
                pending_next = {pending_reg[7:0], data_byte};
                count_next   = cnt_eff + 2'd1;
            end
            else
            begin
                push         = 1'b1;
                pending_next = '0;
                count_next   = '0;
                if (cnt_eff == 2'd1)
                begin
                    push_group.word    = {pending_reg[7:0], data_byte, 8'd0};
                    push_group.pad_cnt = 2'd1;
                end
                else
                begin
                    push_group.word    = {data_byte, 16'd0};
                    push_group.pad_cnt = 2'd2;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            count_reg   <= count_next;
        end
    end

endmodule

>>> rtl/core/b64e_queue.sv
module b64e_queue
    import b64e_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  group_t push_group,
    output logic   full,
    input  logic   pop,
    output logic   q_valid,
    output group_t q_group
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [PW-1:0] PTR_ONE  = PW'(1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    group_t        mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full    = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_group = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_ONE;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_ONE;
            if (push && !pop)
                count_reg <= count_reg + CNT_ONE;
            else if (pop && !push)
                count_reg <= count_reg - CNT_ONE;
        end
    end

endmodule

>>> rtl/core/b64e_back.sv
module b64e_back
    import b64e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  group_t     q_group,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] out_char,
    output logic       last_char
);

    group_t     grp_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       ovalid_reg;
    logic [6:0] char_reg;
    logic       lastc_reg;

    logic       advance;
    logic       grp_done;
    logic [5:0] sext;
    logic       is_pad;
    logic [6:0] char_next;

    assign advance  = busy_reg && (!ovalid_reg || out_ready);
    assign grp_done = advance && (idx_reg == 2'd3);
    assign pop      = q_valid && (!busy_reg || grp_done);

    always_comb
    begin
        unique case (idx_reg)
            2'd0: sext = grp_reg.word[23:18];
            2'd1: sext = grp_reg.word[17:12];
            2'd2: sext = grp_reg.word[11:6];
            2'd3: sext = grp_reg.word[5:0];
        endcase
        // pad_cnt trailing slots become '='
        is_pad    = ({1'b0, idx_reg} >= (3'd4 - {1'b0, grp_reg.pad_cnt}));
        char_next = is_pad ? PAD_CHAR : b64_char(sext & SIX_MASK);
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            grp_reg <= q_group;
        if (advance)
        begin
            char_reg  <= char_next;
            lastc_reg <= grp_reg.last && (idx_reg == 2'd3);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                busy_reg <= 1'b1;
            else if (grp_done)
                busy_reg <= 1'b0;
            if (advance)
                idx_reg <= idx_reg + 2'd1;
            if (advance)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_char  = char_reg;
    assign last_char = lastc_reg;

endmodule
